>>> design/conveyor_fault_handler_fsm_assert.svh
// Assertion macros shared by the conveyor fault handler modules.
`ifndef CONVEYOR_FAULT_HANDLER_FSM_ASSERT_SVH
`define CONVEYOR_FAULT_HANDLER_FSM_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked property that is not checked while reset is asserted.
`define CFH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cfh assertion failed");

// Clocked property that is checked in every cycle, reset included.
`define CFH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("cfh assertion failed");

`else

`define CFH_ASSERT(lbl, clk, rst_n, prop)
`define CFH_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> design/cfh_pkg.sv
package cfh_pkg;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_SLIDE     = 4'd1,
        M_SLIDE_ACK = 4'd2,
        M_TURN      = 4'd3,
        M_ERR       = 4'd4,
        M_ERR_ACK   = 4'd5,
        M_BAND2     = 4'd6,
        M_BAND2_ACK = 4'd7,
        M_ESTOP     = 4'd8,
        M_ESTOP_ACK = 4'd9,
        M_STOP      = 4'd10
    } mode_t;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_SER_ESTOP    = 4'd1,
        EV_ESTOP        = 4'd2,
        EV_ESTOP_REL    = 4'd3,
        EV_STOP         = 4'd4,
        EV_START        = 4'd5,
        EV_RESET        = 4'd6,
        EV_SLIDE_CLEAR  = 4'd7,
        EV_END_OPEN     = 4'd8,
        EV_START_SENSOR = 4'd9,
        EV_F_SLIDE      = 4'd10,
        EV_F_TURN       = 4'd11,
        EV_F_ERR        = 4'd12,
        EV_F_BAND2      = 4'd13
    } ev_code_t;

    typedef enum logic [2:0] {
        LIGHT_NONE   = 3'd0,
        LIGHT_FAULT  = 3'd1,
        LIGHT_ACK    = 3'd2,
        LIGHT_GONE   = 3'd3,
        LIGHT_TURN   = 3'd4,
        LIGHT_NORMAL = 3'd5,
        LIGHT_HALT   = 3'd6
    } light_t;

    typedef enum logic [1:0] {
        NOTICE_NONE  = 2'd0,
        NOTICE_SET   = 2'd1,
        NOTICE_CLEAR = 2'd2
    } notice_t;

    localparam logic [1:0] SRC_IRQ  = 2'd0;
    localparam logic [1:0] SRC_ITEM = 2'd1;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // One event as it enters the controller; the code is still the raw value.
    typedef struct packed {
        logic [1:0] event_source;
        logic [3:0] event_code;
        logic       drive_stopped;
    } evt_t;

    typedef struct packed {
        logic    motor_hold;
        logic    motor_release;
        logic    motor_restore_stop;
        logic    gate_close;
        light_t  light_cmd;
        logic    fault_solved_reply;
        notice_t estop_notice;
        logic    item_reset;
        logic    revoke_drive_right;
        mode_t   mode_now;
    } res_t;

endpackage

>>> design/cfh_ctrl.sv
`include "conveyor_fault_handler_fsm_assert.svh"

module cfh_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  cfh_pkg::evt_t evt,
    output cfh_pkg::res_t res
);
    import cfh_pkg::*;

    mode_t mode_reg, mode_next;
    mode_t saved_mode_reg, saved_mode_next;
    logic  estop_latched_reg, estop_latched_next;
    logic  stop_latched_reg, stop_latched_next;
    logic  drive_was_stopped_reg, drive_was_stopped_next;
    logic  start_sensor_seen_reg, start_sensor_seen_next;

    mode_t    mode_mid;
    ev_code_t code;
    logic     irq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg              <= M_IDLE;
            saved_mode_reg        <= M_IDLE;
            estop_latched_reg     <= 1'b0;
            stop_latched_reg      <= 1'b0;
            drive_was_stopped_reg <= 1'b0;
            start_sensor_seen_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg              <= mode_next;
            saved_mode_reg        <= saved_mode_next;
            estop_latched_reg     <= estop_latched_next;
            stop_latched_reg      <= stop_latched_next;
            drive_was_stopped_reg <= drive_was_stopped_next;
            start_sensor_seen_reg <= start_sensor_seen_next;
        end
    end

    always_comb begin
        // Codes above the last item fault mean no event.
        code = (evt.event_code > EV_F_BAND2) ? EV_NONE : ev_code_t'(evt.event_code);
        irq  = (evt.event_source == SRC_IRQ);

        saved_mode_next        = saved_mode_reg;
        estop_latched_next     = estop_latched_reg;
        stop_latched_next      = stop_latched_reg;
        drive_was_stopped_next = drive_was_stopped_reg;
        start_sensor_seen_next = start_sensor_seen_reg;
        mode_mid               = mode_reg;

        res = '0;
        res.light_cmd    = LIGHT_NONE;
        res.estop_notice = NOTICE_NONE;

        // Emergency stop and stop take priority over the mode handler.
        if ((code == EV_SER_ESTOP || code == EV_ESTOP) && !estop_latched_reg) begin
            estop_latched_next = 1'b1;
            res.estop_notice   = NOTICE_SET;
            mode_mid           = M_ESTOP;
        end else if (code == EV_STOP && !stop_latched_reg) begin
            stop_latched_next      = 1'b1;
            drive_was_stopped_next = evt.drive_stopped;
            saved_mode_next        = mode_reg;
            mode_mid               = M_STOP;
        end

        mode_next = mode_mid;

        unique case (mode_mid)
            M_IDLE: begin
                if (evt.event_source == SRC_ITEM) begin
                    case (code)
                        EV_F_SLIDE: begin
                            res.motor_hold = 1'b1;
                            res.light_cmd  = LIGHT_FAULT;
                            mode_next      = M_SLIDE;
                        end
                        EV_F_TURN: begin
                            res.motor_hold = 1'b1;
                            res.light_cmd  = LIGHT_TURN;
                            mode_next      = M_TURN;
                        end
                        EV_F_ERR: begin
                            res.motor_hold = 1'b1;
                            res.light_cmd  = LIGHT_FAULT;
                            mode_next      = M_ERR;
                        end
                        EV_F_BAND2: begin
                            res.motor_hold = 1'b1;
                            res.light_cmd  = LIGHT_FAULT;
                            mode_next      = M_BAND2;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            M_SLIDE: begin
                res.motor_hold = 1'b1;
                res.light_cmd  = LIGHT_FAULT;
                if (irq && code == EV_SLIDE_CLEAR) begin
                    res.light_cmd = LIGHT_GONE;
                end else if (irq && code == EV_RESET) begin
                    res.light_cmd = LIGHT_ACK;
                    mode_next     = M_SLIDE_ACK;
                end
            end
            M_TURN: begin
                res.motor_hold = 1'b1;
                res.light_cmd  = LIGHT_TURN;
                if (irq && code == EV_END_OPEN) begin
                    res.light_cmd          = LIGHT_NORMAL;
                    res.fault_solved_reply = 1'b1;
                    res.motor_release      = 1'b1;
                    mode_next              = M_IDLE;
                end
            end
            M_ERR, M_BAND2: begin
                res.motor_hold = 1'b1;
                res.light_cmd  = LIGHT_FAULT;
                if (irq && code == EV_RESET) begin
                    res.light_cmd = LIGHT_ACK;
                    mode_next     = (mode_mid == M_ERR) ? M_ERR_ACK : M_BAND2_ACK;
                end
            end
            M_SLIDE_ACK, M_ERR_ACK: begin
                if (irq && code == EV_START) begin
                    res.light_cmd          = LIGHT_NORMAL;
                    res.fault_solved_reply = 1'b1;
                    res.motor_release      = 1'b1;
                    mode_next              = M_IDLE;
                end
            end
            M_BAND2_ACK: begin
                // Restart needs the start sensor to have opened first.
                if (irq && code == EV_START_SENSOR) begin
                    start_sensor_seen_next = 1'b1;
                end else if (irq && code == EV_START && start_sensor_seen_reg) begin
                    start_sensor_seen_next = 1'b0;
                    res.light_cmd          = LIGHT_NORMAL;
                    res.fault_solved_reply = 1'b1;
                    res.motor_release      = 1'b1;
                    mode_next              = M_IDLE;
                end
            end
            M_ESTOP: begin
                res.motor_hold = 1'b1;
                res.light_cmd  = LIGHT_FAULT;
                res.gate_close = 1'b1;
                if (irq && code == EV_ESTOP_REL && estop_latched_next) begin
                    res.light_cmd = LIGHT_ACK;
                    mode_next     = M_ESTOP_ACK;
                end
            end
            M_ESTOP_ACK: begin
                if (irq && code == EV_RESET) begin
                    estop_latched_next     = 1'b0;
                    res.item_reset         = 1'b1;
                    res.light_cmd          = LIGHT_NORMAL;
                    res.motor_release      = 1'b1;
                    res.revoke_drive_right = 1'b1;
                    res.estop_notice       = NOTICE_CLEAR;
                    mode_next              = M_IDLE;
                end
            end
            M_STOP: begin
                res.motor_hold = 1'b1;
                res.light_cmd  = LIGHT_HALT;
                if (irq && code == EV_START) begin
                    stop_latched_next      = 1'b0;
                    res.light_cmd          = LIGHT_NORMAL;
                    res.motor_release      = 1'b1;
                    res.motor_restore_stop = drive_was_stopped_next;
                    mode_next              = saved_mode_next;
                end
            end
            default: begin
                mode_next = M_IDLE;
            end
        endcase

        res.mode_now = mode_next;
    end

    `CFH_ASSERT(a_estop_modes_latched, aclk, aresetn, (mode_reg == M_ESTOP || mode_reg == M_ESTOP_ACK) |-> estop_latched_reg)
    `CFH_ASSERT(a_stop_mode_latched, aclk, aresetn, (mode_reg == M_STOP) |-> stop_latched_reg)
    `CFH_ASSERT(a_item_reset_clears, aclk, aresetn, (step_en && res.item_reset) |=> (mode_reg == M_IDLE && !estop_latched_reg))
    `CFH_ASSERT(a_restore_leaves_stop, aclk, aresetn, (step_en && res.motor_restore_stop) |=> !stop_latched_reg)

endmodule

>>> design/conveyor_fault_handler_fsm.sv
// Conveyor fault and emergency-stop controller. Each input transaction carries one
// event (source, event code, drive-stopped flag) and produces exactly one result
// transaction with the action strobes, the light command and the new mode. The block
// takes one transaction per clock cycle unless the output stalls; an accepted event
// is held in the input register and its result in the result register, with the
// combinational next-state decision of the mode controller in between. Events are
// handled strictly in order, and either side may stall without loss.
`include "conveyor_fault_handler_fsm_assert.svh"

module conveyor_fault_handler_fsm (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] event_source, [5:2] event_code, [6] drive_stopped, [7] zero
    input  logic [cfh_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] motor_hold, [1] motor_release, [2] motor_restore_stop, [3] gate_close,
    // [6:4] light_cmd, [7] fault_solved_reply, [9:8] estop_notice, [10] item_reset,
    // [11] revoke_drive_right, [15:12] mode_now
    output logic [cfh_pkg::M_DATA_W-1:0]  m_tdata
);
    import cfh_pkg::*;

    logic                in_valid_reg, in_valid_next;
    evt_t                in_evt_reg, in_evt_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic advance;
    res_t res;

    cfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .evt     (in_evt_reg),
        .res     (res)
    );

    // The held event moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_evt_next   = in_evt_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next            = 1'b1;
            in_evt_next.event_source = s_tdata[1:0];
            in_evt_next.event_code   = s_tdata[5:2];
            in_evt_next.drive_stopped = s_tdata[6];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = {res.mode_now, res.revoke_drive_right, res.item_reset,
                              res.estop_notice, res.fault_solved_reply, res.light_cmd,
                              res.gate_close, res.motor_restore_stop, res.motor_release,
                              res.motor_hold};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_evt_reg   <= in_evt_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `CFH_ASSERT(a_advance_fills_output, aclk, aresetn, advance |=> out_valid_reg)
    `CFH_ASSERT(a_stall_keeps_event, aclk, aresetn, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_evt_reg)))
    `CFH_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> (!in_valid_reg && !out_valid_reg))

endmodule
